### design/sma_pkg.sv
// Shared types and constants for the stack machine arithmetic unit.
// Used by the controller, the datapath, the divider, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package sma_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int OPCODE_W    = 3;
	localparam int STATUS_W    = 2;
	localparam int DEPTH_OUT_W = 7;
	localparam int CNT_W       = $clog2(DATA_W);

	// Stream widths: input tdata holds push_value, output tdata holds top and depth
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 40;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH = 3'd0,
		OP_SWAP = 3'd1,
		OP_ADD  = 3'd2,
		OP_SUB  = 3'd3,
		OP_DIV  = 3'd4,
		OP_MUL  = 3'd5
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_DIVZERO = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_WB
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic div_start;
		logic commit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_div;
		logic out_free;
		logic div_busy;
	} dp_sts_t;

endpackage

`default_nettype wire

### design/sma_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on sma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sma_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [sma_pkg::DATA_W-1:0] dividend,
	input  wire logic [sma_pkg::DATA_W-1:0] divisor,
	output logic                            busy,
	output logic [sma_pkg::DATA_W-1:0]      quotient
);
	import sma_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;

	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic              fits;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		shifted = {rem_q, quo_q[DATA_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		fits    = !diff[DATA_W];
	end

	// Control: count through the quotient bits while busy, then go idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: load magnitudes, then shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[DATA_W-1] ? (-dividend) : dividend;
			dvs_q <= divisor[DATA_W-1] ? (-divisor) : divisor;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? (-quo_q) : quo_q;

endmodule

`default_nettype wire

### design/sma_dp.sv
// Datapath: stack memory, top-of-stack and depth registers, ALU, divider and result register.
// Depends on sma_pkg and sma_div.
`timescale 1ns / 1ps
`default_nettype none

module sma_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sma_pkg::dp_cmd_t              cmd,
	output sma_pkg::dp_sts_t                   sts,
	input  wire logic [sma_pkg::OPCODE_W-1:0]  in_opcode,
	input  wire logic [sma_pkg::DATA_W-1:0]    in_value,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic [sma_pkg::STATUS_W-1:0]       out_status,
	output logic [sma_pkg::DATA_W-1:0]         out_top,
	output logic [sma_pkg::DEPTH_OUT_W-1:0]    out_depth
);
	import sma_pkg::*;

	// Entries below the top of stack; the top itself lives in top_q
	logic [DATA_W-1:0] mem [STACK_DEPTH];

	logic [OPCODE_W-1:0] op_q;
	logic [DATA_W-1:0]   val_q;
	logic [DATA_W-1:0]   rd_q;
	logic [DATA_W-1:0]   top_q;
	logic [DEPTH_W-1:0]  depth_q;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [DATA_W-1:0]    out_top_q;
	logic [DEPTH_W-1:0]   out_depth_q;

	logic [DATA_W-1:0]    nxt_top;
	logic [DEPTH_W-1:0]   nxt_depth;
	status_t              nxt_status;
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [DATA_W-1:0]    wr_data;
	logic [2*DATA_W-1:0]  prod;
	logic                 two_or_more;
	logic                 full;
	logic [DATA_W-1:0]    div_quot;
	logic                 div_busy;

	sma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_q),
		.divisor  (top_q),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	assign two_or_more = depth_q >= DEPTH_W'(2);
	assign full        = depth_q == DEPTH_W'(STACK_DEPTH);
	assign prod        = rd_q * top_q;

	// Capture the request and read the second entry
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_opcode;
			val_q <= in_value;
			rd_q  <= mem[ADDR_W'(depth_q - DEPTH_W'(2))];
		end
	end

	// Spill to or update the stack memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Next stack state for the captured request
	always_comb begin
		nxt_top    = top_q;
		nxt_depth  = depth_q;
		nxt_status = ST_OK;
		wr_en      = 1'b0;
		wr_addr    = ADDR_W'(depth_q - DEPTH_W'(1));
		wr_data    = top_q;
		unique case (op_q)
			OP_PUSH: begin
				if (full) begin
					nxt_status = ST_FULL;
				end else begin
					wr_en     = cmd.commit && (depth_q != '0);
					nxt_top   = val_q;
					nxt_depth = depth_q + DEPTH_W'(1);
				end
			end
			OP_SWAP, OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
				if (!two_or_more) begin
					nxt_status = ST_SHORT;
				end else begin
					unique case (op_q)
						OP_SWAP: begin
							wr_en   = cmd.commit;
							wr_addr = ADDR_W'(depth_q - DEPTH_W'(2));
							nxt_top = rd_q;
						end
						OP_ADD: begin
							nxt_top   = rd_q + top_q;
							nxt_depth = depth_q - DEPTH_W'(1);
						end
						OP_SUB: begin
							nxt_top   = rd_q - top_q;
							nxt_depth = depth_q - DEPTH_W'(1);
						end
						OP_MUL: begin
							nxt_top   = prod[DATA_W-1:0];
							nxt_depth = depth_q - DEPTH_W'(1);
						end
						default: begin
							if (top_q == '0) begin
								nxt_status = ST_DIVZERO;
							end else begin
								nxt_top   = div_quot;
								nxt_depth = depth_q - DEPTH_W'(1);
							end
						end
					endcase
				end
			end
			default: begin
				// Unused opcodes leave the stack alone
			end
		endcase
		// Any error empties the stack
		if (nxt_status != ST_OK) begin
			nxt_depth = '0;
		end
	end

	// Commit stack state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.commit) begin
			depth_q <= nxt_depth;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			top_q <= nxt_top;
		end
	end

	// Result register, held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= nxt_status;
			out_top_q    <= (nxt_depth == '0) ? '0 : nxt_top;
			out_depth_q  <= nxt_depth;
		end
	end

	assign sts.need_div = (op_q == OP_DIV) && two_or_more && (top_q != '0);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.div_busy = div_busy;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_top    = out_top_q;
	assign out_depth  = DEPTH_OUT_W'(out_depth_q);

endmodule

`default_nettype wire

### design/sma_ctrl.sv
// Controller state machine: sequences capture, execute, divide and write-back.
// Depends on sma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sma_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire sma_pkg::dp_sts_t sts,
	output sma_pkg::dp_cmd_t      cmd
);
	import sma_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.need_div) begin
					state_nxt = S_DIV;
				end else if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_DIV: begin
				if (!sts.div_busy) begin
					state_nxt = S_WB;
				end
			end
			S_WB: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.div_start = 1'b0;
		cmd.commit    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_EXEC: begin
				cmd.div_start = sts.need_div;
				cmd.commit    = !sts.need_div && sts.out_free;
			end
			S_DIV: begin
				// wait for the divider
			end
			S_WB: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/stack_machine_arith_unit.sv
// Top level of the stack machine arithmetic unit: stream ports, controller and datapath.
// Depends on sma_pkg, sma_ctrl and sma_dp.
//
//   channel | dir | tdata                        | tuser
//   s_*     | in  | [31:0] push_value            | [2:0] opcode
//   m_*     | out | [31:0] top_value,            | [1:0] status
//           |     | [38:32] stack_depth, zero pad|
//
// One request is in flight at a time. Push, swap, add, sub, mul, no-ops and errors are captured
// in idle and committed to the output register from execute; a valid div goes on through
// divide and write-back first, and the divider retires one quotient bit per cycle.
// A new request is taken while the last result still waits in the output register.
// A stalled result holds the block in execute or write-back until the register frees.
// Reset empties the stack; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_arith_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [sma_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] push_value
	input  wire logic [sma_pkg::OPCODE_W-1:0]  s_tuser,  // [2:0] opcode
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [sma_pkg::M_TDATA_W-1:0]      m_tdata,  // [31:0] top_value, [38:32] stack_depth
	output logic [sma_pkg::STATUS_W-1:0]       m_tuser   // [1:0] status
);
	import sma_pkg::*;

	dp_cmd_t                 cmd;
	dp_sts_t                 sts;
	logic [DATA_W-1:0]       out_top;
	logic [DEPTH_OUT_W-1:0]  out_depth;

	sma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sma_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_opcode  (s_tuser),
		.in_value   (s_tdata[DATA_W-1:0]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (m_tuser),
		.out_top    (out_top),
		.out_depth  (out_depth)
	);

	// Pack the result, zero pad to whole bytes
	assign m_tdata = {{(M_TDATA_W - DATA_W - DEPTH_OUT_W){1'b0}}, out_depth, out_top};

endmodule

`default_nettype wire

### design/sma_checker.sv
// Port-level checks for the stack machine arithmetic unit, bound to the top level.
// Depends on sma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sma_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [sma_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [sma_pkg::OPCODE_W-1:0]  s_tuser,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [sma_pkg::M_TDATA_W-1:0] m_tdata,
	input  wire logic [sma_pkg::STATUS_W-1:0]  m_tuser
);
	import sma_pkg::*;

	// Hold an offered request until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("offered request changed before acceptance");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// Any error reports an empty stack
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[DATA_W+DEPTH_OUT_W-1:0] == '0))
		else $error("error result with nonempty stack");

	// Depth never exceeds the stack size
	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[DATA_W+DEPTH_OUT_W-1:DATA_W] <= DEPTH_OUT_W'(STACK_DEPTH)))
		else $error("depth beyond stack size");

	// An empty stack shows a zero top
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[DATA_W+DEPTH_OUT_W-1:DATA_W] == '0)
			|-> (m_tdata[DATA_W-1:0] == '0))
		else $error("empty stack with nonzero top");

endmodule

bind stack_machine_arith_unit sma_checker u_sma_checker (.*);

`default_nettype wire

### sim/tb_stack_machine_arith_unit.sv
// Self-checking testbench for stack_machine_arith_unit: directed table, then shaped random traffic.
// Depends on sma_pkg and the block under test; predicts results with its own stack model where the table gives none.
`timescale 1ns / 1ps

module tb_stack_machine_arith_unit;
	import sma_pkg::*;

	localparam int CLK_PERIOD  = 20;
	localparam int ITEM_TARGET = 1250;
	localparam int IDLE_LIMIT  = 1000;
	localparam int DRAIN_WAIT  = 50;
	localparam int MAX_REPORTS = 10;

	// Opcodes the block decodes as no-ops
	localparam logic [OPCODE_W-1:0] OP_UNUSED_A = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_UNUSED_B = 3'd7;

	typedef struct {
		status_t                  status;
		logic [DATA_W-1:0]        top;
		logic [DEPTH_OUT_W-1:0]   depth;
	} stack_result_t;

	typedef struct {
		logic [OPCODE_W-1:0]      op;
		logic [DATA_W-1:0]        value;
		bit                       fixed;
		status_t                  status;
		logic [DATA_W-1:0]        top;
		logic [DEPTH_OUT_W-1:0]   depth;
	} directed_row_t;

	typedef enum int {
		MODE_MIX,
		MODE_FILL,
		MODE_NOISE
	} traffic_mode_t;

	logic                    clk      = 1'b0;
	logic                    arst_n   = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [S_TDATA_W-1:0]    s_tdata  = '0;
	logic [OPCODE_W-1:0]     s_tuser  = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [M_TDATA_W-1:0]    m_tdata;
	logic [STATUS_W-1:0]     m_tuser;

	// Shadow stack tracked at request acceptance
	logic [DATA_W-1:0]       stack_mem [STACK_DEPTH];
	int                      depth_cnt = 0;

	stack_result_t           pending_results[$];
	int                      fail_count    = 0;
	int                      items_sent    = 0;
	int                      results_seen  = 0;
	int                      idle_cycles   = 0;
	int                      status_seen [4] = '{0, 0, 0, 0};
	bit                      src_burst     = 1'b0;
	bit                      sink_burst    = 1'b0;

	directed_row_t directed_rows [25] = '{
		'{OP_SWAP,     32'h0000_0000, 1'b1, ST_SHORT,   32'h0000_0000, 7'd0},
		'{OP_ADD,      32'h1234_5678, 1'b1, ST_SHORT,   32'h0000_0000, 7'd0},
		'{OP_DIV,      32'h0000_0000, 1'b1, ST_SHORT,   32'h0000_0000, 7'd0},
		'{OP_PUSH,     32'h7FFF_FFFF, 1'b1, ST_OK,      32'h7FFF_FFFF, 7'd1},
		'{OP_SUB,      32'h0000_0000, 1'b1, ST_SHORT,   32'h0000_0000, 7'd0},
		'{OP_PUSH,     32'h8000_0000, 1'b1, ST_OK,      32'h8000_0000, 7'd1},
		'{OP_PUSH,     32'hFFFF_FFFF, 1'b1, ST_OK,      32'hFFFF_FFFF, 7'd2},
		'{OP_DIV,      32'h0000_0000, 1'b1, ST_OK,      32'h8000_0000, 7'd1},
		'{OP_PUSH,     32'h0000_0000, 1'b1, ST_OK,      32'h0000_0000, 7'd2},
		'{OP_DIV,      32'hFFFF_FFFF, 1'b1, ST_DIVZERO, 32'h0000_0000, 7'd0},
		'{OP_PUSH,     32'hFFFF_FFF9, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_PUSH,     32'h0000_0002, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_DIV,      32'h0000_0000, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_PUSH,     32'h7FFF_FFFF, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_PUSH,     32'h0000_0001, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_ADD,      32'hFFFF_FFFF, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_PUSH,     32'h8000_0000, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_SWAP,     32'h0000_0000, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_SUB,      32'h0000_0000, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_PUSH,     32'h0001_0001, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_MUL,      32'h0000_0000, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_UNUSED_A, 32'hAAAA_5555, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_UNUSED_B, 32'h5555_AAAA, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_PUSH,     32'hFFFF_FFFF, 1'b0, ST_OK,      32'h0,         7'd0},
		'{OP_MUL,      32'h0000_0000, 1'b0, ST_OK,      32'h0,         7'd0}
	};

	stack_machine_arith_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Free-running clock
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Apply one instruction to the shadow stack and return what the block should report
	function automatic stack_result_t apply_instruction(input logic [OPCODE_W-1:0] op,
			input logic [DATA_W-1:0] value);
		stack_result_t     res;
		logic [DATA_W-1:0] lhs;
		logic [DATA_W-1:0] rhs;
		logic [DATA_W-1:0] folded;
		longint            quo;
		bit                pops;
		res.status = ST_OK;
		folded = '0;
		pops = 1'b0;
		if (op == OP_PUSH) begin
			if (depth_cnt >= STACK_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				stack_mem[depth_cnt] = value;
				depth_cnt++;
			end
		end else if (op <= OP_MUL) begin
			if (depth_cnt < 2) begin
				res.status = ST_SHORT;
			end else begin
				lhs = stack_mem[depth_cnt-2];
				rhs = stack_mem[depth_cnt-1];
				pops = 1'b1;
				case (op)
					OP_ADD: folded = lhs + rhs;
					OP_SUB: folded = lhs - rhs;
					OP_MUL: folded = lhs * rhs;
					OP_DIV: begin
						if (rhs == '0) begin
							res.status = ST_DIVZERO;
							pops = 1'b0;
						end else begin
							// 64-bit quotient so min / -1 wraps instead of trapping
							quo = longint'($signed(lhs)) / longint'($signed(rhs));
							folded = quo[DATA_W-1:0];
						end
					end
					default: begin
						stack_mem[depth_cnt-2] = rhs;
						stack_mem[depth_cnt-1] = lhs;
						pops = 1'b0;
					end
				endcase
				if (pops) begin
					stack_mem[depth_cnt-2] = folded;
					depth_cnt--;
				end
			end
		end
		// Any error empties the stack
		if (res.status != ST_OK)
			depth_cnt = 0;
		res.top = (depth_cnt > 0) ? stack_mem[depth_cnt-1] : '0;
		res.depth = DEPTH_OUT_W'(depth_cnt);
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h7FFF_FFFF;
			4: return 32'h8000_0000;
			5, 6: return DATA_W'($urandom_range(0, 200)) - 32'd100;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [OPCODE_W-1:0] pick_stack_op();
		case ($urandom_range(0, 4))
			0: return OP_SWAP;
			1: return OP_ADD;
			2: return OP_SUB;
			3: return OP_DIV;
			default: return OP_MUL;
		endcase
	endfunction

	// Offer one request after a random gap, hold it until taken, then record its prediction
	task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] value,
			input bit fixed, input stack_result_t fixed_res);
		int            gap;
		stack_result_t predicted;
		if ($urandom_range(0, 15) == 0)
			src_burst = ~src_burst;
		gap = src_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = apply_instruction(op, value);
		pending_results.push_back(fixed ? fixed_res : predicted);
		if (op <= OP_MUL)
			items_sent++;
	endtask

	// Stimulus: reset, directed table, shaped random traffic, drain
	initial begin
		stack_result_t  fixed_res;
		traffic_mode_t  mode;
		int             seg_left;
		logic [OPCODE_W-1:0] op;
		bit             hit_full;
		mode = MODE_MIX;
		seg_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (directed_rows[i]) begin
			fixed_res.status = directed_rows[i].status;
			fixed_res.top    = directed_rows[i].top;
			fixed_res.depth  = directed_rows[i].depth;
			send_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].fixed,
				fixed_res);
		end

		// Random traffic in segments: mostly valid programs, some stack fills, some noise
		while (items_sent < ITEM_TARGET) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(10, 60);
				case ($urandom_range(0, 9))
					0:       mode = MODE_FILL;
					1, 2:    mode = MODE_NOISE;
					default: mode = MODE_MIX;
				endcase
			end
			hit_full = 1'b0;
			case (mode)
				MODE_FILL: begin
					op = OP_PUSH;
					hit_full = (depth_cnt >= STACK_DEPTH);
				end
				MODE_NOISE: op = OPCODE_W'($urandom_range(0, 7));
				default: begin
					if (depth_cnt < 2)
						op = ($urandom_range(0, 99) < 85) ? OP_PUSH : pick_stack_op();
					else if (depth_cnt >= STACK_DEPTH - 2)
						op = ($urandom_range(0, 99) < 30) ? OP_PUSH : pick_stack_op();
					else
						op = ($urandom_range(0, 99) < 45) ? OP_PUSH : pick_stack_op();
				end
			endcase
			send_request(op, (mode == MODE_NOISE) ? $urandom : pick_value(), 1'b0, fixed_res);
			// A fill runs until the overflowing push; other segments run their length
			if (mode == MODE_FILL)
				seg_left = hit_full ? 0 : seg_left;
			else
				seg_left--;
		end
		s_tvalid <= 1'b0;

		// Drain and let the pipeline settle
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_results.size() != 0)
			fail_count++;

		$display("Sent %0d stack requests, checked %0d results.", items_sent, results_seen);
		$display("Statuses seen: ok %0d, too short %0d, divide by zero %0d, stack full %0d.",
			status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_DIVZERO],
			status_seen[ST_FULL]);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Result sink: random stalls, compare each result with the oldest prediction
	initial begin
		int            stall;
		stack_result_t want;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				sink_burst = ~sink_burst;
			stall = sink_burst ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			results_seen++;
			status_seen[m_tuser]++;
			if (pending_results.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("[%0t] result with nothing pending: status %0d top %h depth %0d",
						$realtime, m_tuser, m_tdata[31:0], m_tdata[38:32]);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.status || m_tdata[31:0] != want.top ||
						m_tdata[38:32] != want.depth) begin
					if (fail_count < MAX_REPORTS)
						$display("[%0t] mismatch: expected status %0d top %h depth %0d, got status %0d top %h depth %0d",
							$realtime, want.status, want.top, want.depth,
							m_tuser, m_tdata[31:0], m_tdata[38:32]);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: stop if no request moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles.", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
